@@ rtl/core/cms_pkg.sv @@
// Shared types and constants for the control mode supervisor.
`timescale 1ns / 1ps
package cms_pkg;

  // Operating modes, same encoding as the request field
  typedef enum logic [2:0] {
    MODE_DISABLED = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_SWING_UP = 3'd2,
    MODE_CAPTURE  = 3'd3,
    MODE_BALANCE  = 3'd4,
    MODE_FAULT    = 3'd5
  } mode_t;

  // Command codes
  localparam logic [1:0] CMD_MODE_REQ  = 2'd0;
  localparam logic [1:0] CMD_CLEAR_REQ = 2'd1;
  localparam logic [1:0] CMD_TICK      = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SWING_UP_EN = 1'b0;
  localparam logic CFG_CAPTURE_EN  = 1'b1;

  // Supervisor state
  typedef struct packed {
    mode_t mode;
    mode_t pending;
    logic  clear_pend;
  } sup_state_t;

  // One result item
  typedef struct packed {
    logic  accepted;
    mode_t mode;
    logic  mode_active;
    logic  admission_ready;
  } sup_result_t;

  function automatic logic is_active(input mode_t m);
    return (m == MODE_SWING_UP) || (m == MODE_CAPTURE) || (m == MODE_BALANCE);
  endfunction

endpackage

@@ rtl/core/cms_mode_logic.sv @@
// Next-state and result logic for one supervisor item.
`timescale 1ns / 1ps
module cms_mode_logic import cms_pkg::*; (
  input  sup_state_t  state_cur,
  input  logic [1:0]  cmd,
  input  logic [2:0]  mode_request,
  input  logic        safety_trip,
  input  logic        ctrl_permit,
  input  logic        swing_up_en,
  input  logic        capture_en,
  output sup_state_t  state_nxt,
  output sup_result_t result
);

  logic  permitted;
  logic  accepted;
  mode_t req;

  // Enable check on the pending mode
  always_comb begin
    req = state_cur.pending;
    case (req)
      MODE_SWING_UP: permitted = swing_up_en;
      MODE_CAPTURE:  permitted = capture_en;
      default:       permitted = 1'b1;
    endcase
  end

  // Command decode and tick priority rules
  always_comb begin
    state_nxt = state_cur;
    accepted  = 1'b1;
    case (cmd)
      CMD_MODE_REQ: begin
        if (mode_request inside {[MODE_DISABLED : MODE_FAULT]}) begin
          state_nxt.pending = mode_t'(mode_request);
        end else begin
          accepted = 1'b0;
        end
      end
      CMD_CLEAR_REQ: begin
        state_nxt.clear_pend = 1'b1;
      end
      CMD_TICK: begin
        state_nxt.clear_pend = 1'b0;
        if (state_cur.mode == MODE_FAULT) begin
          if (state_cur.clear_pend && !safety_trip) begin
            state_nxt.mode    = MODE_DISABLED;
            state_nxt.pending = MODE_DISABLED;
          end
        end else if (safety_trip && state_cur.mode != MODE_DISABLED) begin
          state_nxt.mode    = MODE_FAULT;
          state_nxt.pending = MODE_FAULT;
        end else if (req == MODE_FAULT || req == MODE_DISABLED) begin
          state_nxt.mode = req;
        end else if (req == MODE_IDLE) begin
          if (!safety_trip) begin
            state_nxt.mode = MODE_IDLE;
          end
        end else if (permitted) begin
          if (ctrl_permit) begin
            state_nxt.mode = req;
          end else if (is_active(state_cur.mode)) begin
            state_nxt.mode    = MODE_IDLE;
            state_nxt.pending = MODE_IDLE;
          end
        end
      end
      default: begin
        // unused command code: no change
      end
    endcase
  end

  // Result fields follow the mode after this item
  always_comb begin
    result.accepted        = accepted;
    result.mode            = state_nxt.mode;
    result.mode_active     = is_active(state_nxt.mode);
    result.admission_ready = is_active(state_nxt.mode) || (state_nxt.mode == MODE_IDLE);
  end

endmodule

@@ rtl/core/control_mode_supervisor_unit.sv @@
// Control mode supervisor: top level with input and result registers.
// Each item goes through the input register and then the result register.
// Throughput: one item per cycle while out_stall does not back up the result;
// the mode decision is a single pass of short logic between the two registers.
// Reset (rst_n, synchronous, active low): mode and pending mode disabled,
// clear flag and enables cleared, both pipeline stages empty.
`timescale 1ns / 1ps
module control_mode_supervisor_unit import cms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [2:0] in_mode_request,
  input  logic       in_safety_trip,
  input  logic       in_ctrl_permit,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_accepted,
  output logic [2:0] out_current_mode,
  output logic       out_mode_active,
  output logic       out_admission_ready,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata
);

  logic        swing_up_en_r;
  logic        capture_en_r;
  sup_state_t  state_r;
  sup_state_t  state_nxt;
  sup_result_t result_nxt;
  sup_result_t result_r;

  logic        s1_valid_r;
  logic [1:0]  s1_cmd_r;
  logic [2:0]  s1_mode_request_r;
  logic        s1_safety_trip_r;
  logic        s1_ctrl_permit_r;
  logic        out_valid_r;

  logic        s1_adv;
  logic        in_xfer;

  // Pipeline flow control
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swing_up_en_r <= 1'b0;
      capture_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SWING_UP_EN: swing_up_en_r <= cfg_wdata;
        CFG_CAPTURE_EN:  capture_en_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r          <= in_cmd;
      s1_mode_request_r <= in_mode_request;
      s1_safety_trip_r  <= in_safety_trip;
      s1_ctrl_permit_r  <= in_ctrl_permit;
    end
  end

  // Mode decision
  cms_mode_logic u_mode_logic (
    .state_cur    (state_r),
    .cmd          (s1_cmd_r),
    .mode_request (s1_mode_request_r),
    .safety_trip  (s1_safety_trip_r),
    .ctrl_permit  (s1_ctrl_permit_r),
    .swing_up_en  (swing_up_en_r),
    .capture_en   (capture_en_r),
    .state_nxt    (state_nxt),
    .result       (result_nxt)
  );

  // Supervisor state commits when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode       <= MODE_DISABLED;
      state_r.pending    <= MODE_DISABLED;
      state_r.clear_pend <= 1'b0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = result_r.accepted;
  assign out_current_mode    = result_r.mode;
  assign out_mode_active     = result_r.mode_active;
  assign out_admission_ready = result_r.admission_ready;

  // Fault is only ever left toward disabled
  a_fault_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r.mode) == MODE_FAULT) && (state_r.mode != MODE_FAULT)
      |-> state_r.mode == MODE_DISABLED)
    else $error("fault left to a mode other than disabled");

  // Only a tick changes the mode
  a_mode_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_cmd_r != CMD_TICK) |=> $stable(state_r.mode))
    else $error("mode changed on a non-tick item");

  // Every tick clears the pending fault clear
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_cmd_r == CMD_TICK) |=> !state_r.clear_pend)
    else $error("clear request survived a tick");

  // An active mode is always ready for admission
  a_active_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_mode_active |-> out_admission_ready)
    else $error("active mode reported not ready");

endmodule
